// ===== rtl/core/ttt_pkg.sv =====
// ttt_pkg: shared types and constants of the tracked target table.
// Used by ttt_ctrl, ttt_datapath and tracked_target_table; no dependencies.
`timescale 1ns / 1ps
package ttt_pkg;
    localparam int TABLE_ENTRIES = 64;
    localparam int SLOT_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [15:0] EXPIRY_RESET = 16'd300;
    localparam logic [1:0] AG_NO_UPDATE = 2'd3;

    localparam logic [1:0] OP_UPDATE = 2'd0;
    localparam logic [1:0] OP_SWEEP  = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [2:0] ST_UPDATED = 3'd0;
    localparam logic [2:0] ST_CREATED = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_SWEPT   = 3'd3;
    localparam logic [2:0] ST_WORD    = 3'd4;
    localparam logic [2:0] ST_EMPTY   = 3'd5;

    localparam logic [2:0] LAST_WORD = 3'd6;

    // Controller to datapath
    typedef struct packed {
        logic latch;      // capture request fields, clear scan state
        logic scan_rd;    // read slot at scan index
        logic scan_eval;  // evaluate data read for scan index
        logic scan_inc;   // advance scan index
        logic upd_rd;     // read target slot for merge
        logic upd_wr;     // write merged slot back
        logic rd_rd;      // read slot for record words
        logic emit;       // drive one result word
        logic [2:0] word; // record word index
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic scan_done;  // scan index at last entry
        logic target_ok;  // update has a hit or a free slot
        logic read_ok;    // read index in range and used
    } t_stat;
endpackage

// ===== rtl/core/tracked_target_table.sv =====
// Channel  | Direction | Handshake                 | Word
// request  | in        | i_start high, o_busy low  | op, time, key, fields
// result   | out       | o_valid strobe, no stall  | status, index, data, last
// config   | in        | i_cfg_we                  | expiry seconds
// Update and sweep scan all 64 slots through one memory read port; an update
// with a hit or a free slot then does a read-modify-write of the target slot.
// A read emits one record word per cycle; an empty or out-of-range slot gives
// one EMPTY word. Reset clears the valid bits and counter at once; no clearing
// pass. Results cannot be stalled.
`timescale 1ns / 1ps
module tracked_target_table (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_wdata,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [1:0]         i_op,
    input  logic [31:0]        i_now_seconds,
    input  logic [24:0]        i_address,
    input  logic [1:0]         i_airground,
    input  logic [6:0]         i_present_mask,
    input  logic signed [23:0] i_latitude,
    input  logic signed [23:0] i_longitude,
    input  logic signed [17:0] i_altitude_feet,
    input  logic [8:0]         i_track_degrees,
    input  logic [11:0]        i_speed_knots,
    input  logic signed [15:0] i_vertical_rate,
    input  logic [63:0]        i_ident_text,
    output logic               o_valid,
    output logic [2:0]         o_status,
    output logic [2:0]         o_word_index,
    output logic [63:0]        o_data_word,
    output logic               o_last
);
    ttt_pkg::t_cmd  cmd;
    ttt_pkg::t_stat stat;
    logic [15:0] r_expiry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expiry <= ttt_pkg::EXPIRY_RESET;
        end else if (i_cfg_we) begin
            r_expiry <= i_cfg_wdata;
        end
    end

    ttt_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_op(i_op),
        .o_busy(o_busy), .o_cmd(cmd), .i_stat(stat)
    );

    ttt_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_stat(stat),
        .i_expiry(r_expiry), .i_op(i_op), .i_now_seconds(i_now_seconds),
        .i_address(i_address), .i_airground(i_airground),
        .i_present_mask(i_present_mask), .i_latitude(i_latitude),
        .i_longitude(i_longitude), .i_altitude_feet(i_altitude_feet),
        .i_track_degrees(i_track_degrees), .i_speed_knots(i_speed_knots),
        .i_vertical_rate(i_vertical_rate), .i_ident_text(i_ident_text),
        .o_valid(o_valid), .o_status(o_status), .o_word_index(o_word_index),
        .o_data_word(o_data_word), .o_last(o_last)
    );
endmodule

// ===== rtl/core/ttt_datapath.sv =====
// ttt_datapath: slot memory, valid bits, key scan, merge and result formatting.
// Depends on ttt_pkg; driven by ttt_ctrl commands.
`timescale 1ns / 1ps
module ttt_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ttt_pkg::t_cmd         i_cmd,
    output ttt_pkg::t_stat        o_stat,
    input  logic [15:0]           i_expiry,
    input  logic [1:0]            i_op,
    input  logic [31:0]           i_now_seconds,
    input  logic [24:0]           i_address,
    input  logic [1:0]            i_airground,
    input  logic [6:0]            i_present_mask,
    input  logic signed [23:0]    i_latitude,
    input  logic signed [23:0]    i_longitude,
    input  logic signed [17:0]    i_altitude_feet,
    input  logic [8:0]            i_track_degrees,
    input  logic [11:0]           i_speed_knots,
    input  logic signed [15:0]    i_vertical_rate,
    input  logic [63:0]           i_ident_text,
    output logic                  o_valid,
    output logic [2:0]            o_status,
    output logic [2:0]            o_word_index,
    output logic [63:0]           o_data_word,
    output logic                  o_last
);
    localparam int SW = ttt_pkg::SLOT_W;

    // record layout: key25 ag2 flags7 pos48 alt18 motion37 call64 sqk64 times64 cnt32
    typedef struct packed {
        logic [24:0] key;
        logic [1:0]  ag;
        logic [6:0]  flags;
        logic [47:0] pos;
        logic [17:0] alt;
        logic [36:0] motion;
        logic [63:0] call;
        logic [63:0] sqk;
        logic [63:0] times;
        logic [31:0] cnt;
    } t_rec;

    t_rec r_mem [ttt_pkg::TABLE_ENTRIES];
    t_rec r_rdata;
    logic [ttt_pkg::TABLE_ENTRIES-1:0] r_used, n_used;

    // captured request
    logic [1:0]  r_op;
    logic [31:0] r_now;
    logic [24:0] r_addr;
    logic [1:0]  r_ag;
    logic [6:0]  r_mask;
    logic [47:0] r_pos;
    logic [17:0] r_alt;
    logic [8:0]  r_trk;
    logic [11:0] r_spd;
    logic [15:0] r_vr;
    logic [63:0] r_text;

    logic [SW-1:0] r_idx, r_eval_idx;
    logic          r_hit_found, r_free_found, r_target_new;
    logic [SW-1:0] r_target;
    logic [ttt_pkg::CNT_W-1:0] r_freed;
    logic [31:0]   r_total;

    logic [SW-1:0] rd_addr;
    logic [31:0]   age;
    t_rec          merged;
    logic [6:0]    mask_eff;
    logic          in_range;

    assign in_range = (r_addr < 25'(ttt_pkg::TABLE_ENTRIES));
    assign o_stat.scan_done = (r_idx == SW'(ttt_pkg::TABLE_ENTRIES - 1));
    assign o_stat.target_ok = r_hit_found | r_free_found;
    assign o_stat.read_ok   = in_range & r_used[r_addr[SW-1:0]];

    always_comb begin
        priority if (i_cmd.scan_rd) begin
            rd_addr = r_idx;
        end else if (i_cmd.rd_rd) begin
            rd_addr = r_addr[SW-1:0];
        end else begin
            rd_addr = r_target;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_rd || i_cmd.upd_rd || i_cmd.rd_rd) begin
            r_rdata <= r_mem[rd_addr];
        end
        if (i_cmd.upd_wr) begin
            r_mem[r_target] <= merged;
        end
    end

    assign age = r_now - r_rdata.times[63:32];
    assign mask_eff = r_mask[5] ? {1'b0, r_mask[5:0]} : r_mask;

    always_comb begin
        t_rec base;
        base = r_rdata;
        if (r_target_new) begin
            base = '0;
            base.key = r_addr;
            base.ag = ttt_pkg::AG_NO_UPDATE;
        end
        merged = base;
        merged.cnt = base.cnt + 32'd1;
        merged.times[63:32] = r_now;
        if (r_ag != ttt_pkg::AG_NO_UPDATE) merged.ag = r_ag;
        if (r_mask[0]) begin
            merged.pos = r_pos;
            merged.times[31:0] = r_now;
        end
        if (r_mask[1]) merged.alt = r_alt;
        if (r_mask[2]) merged.motion[36:28] = r_trk;
        if (r_mask[3]) merged.motion[27:16] = r_spd;
        if (r_mask[4]) merged.motion[15:0] = r_vr;
        if (r_mask[5]) merged.call = r_text;
        else if (r_mask[6]) merged.sqk = r_text;
        merged.flags = base.flags | mask_eff;
    end

    always_comb begin
        n_used = r_used;
        if (i_cmd.scan_eval && r_op == ttt_pkg::OP_SWEEP && r_used[r_eval_idx] &&
            !age[31] && age > {16'd0, i_expiry}) begin
            n_used[r_eval_idx] = 1'b0;
        end
        if (i_cmd.upd_wr) n_used[r_target] = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= '0;
            r_total <= '0;
        end else begin
            r_used <= n_used;
            if (i_cmd.latch && i_op == ttt_pkg::OP_UPDATE) r_total <= r_total + 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op   <= i_op;
            r_now  <= i_now_seconds;
            r_addr <= i_address;
            r_ag   <= i_airground;
            r_mask <= i_present_mask;
            r_pos  <= {i_latitude, i_longitude};
            r_alt  <= i_altitude_feet;
            r_trk  <= i_track_degrees;
            r_spd  <= i_speed_knots;
            r_vr   <= i_vertical_rate;
            r_text <= i_ident_text;
            r_idx  <= '0;
            r_hit_found  <= 1'b0;
            r_free_found <= 1'b0;
            r_target_new <= 1'b0;
            r_freed <= '0;
        end else begin
            if (i_cmd.scan_rd) r_eval_idx <= r_idx;
            if (i_cmd.scan_inc) r_idx <= r_idx + SW'(1);
            if (i_cmd.scan_eval) begin
                if (r_op == ttt_pkg::OP_SWEEP) begin
                    if (r_used[r_eval_idx] && !age[31] && age > {16'd0, i_expiry})
                        r_freed <= r_freed + ttt_pkg::CNT_W'(1);
                end else if (r_used[r_eval_idx]) begin
                    if (!r_hit_found && r_rdata.key == r_addr) begin
                        r_hit_found  <= 1'b1;
                        r_target     <= r_eval_idx;
                        r_target_new <= 1'b0;
                    end
                end else if (!r_free_found && !r_hit_found) begin
                    // lowest free slot, unless a hit is found later
                    r_free_found <= 1'b1;
                    r_target     <= r_eval_idx;
                    r_target_new <= 1'b1;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_word_index <= '0;
            o_data_word  <= '0;
            o_last       <= 1'b1;
            unique case (r_op)
                ttt_pkg::OP_UPDATE: begin
                    if (!(r_hit_found | r_free_found)) o_status <= ttt_pkg::ST_FULL;
                    else if (r_target_new) o_status <= ttt_pkg::ST_CREATED;
                    else o_status <= ttt_pkg::ST_UPDATED;
                end
                ttt_pkg::OP_SWEEP: begin
                    o_status <= ttt_pkg::ST_SWEPT;
                    o_data_word <= {32'(r_freed), r_total};
                end
                default: begin
                    if (!(in_range & r_used[r_addr[SW-1:0]])) begin
                        o_status <= ttt_pkg::ST_EMPTY;
                    end else begin
                        o_status <= ttt_pkg::ST_WORD;
                        o_word_index <= i_cmd.word;
                        o_last <= (i_cmd.word == ttt_pkg::LAST_WORD);
                        unique case (i_cmd.word)
                            3'd0: o_data_word <= {30'd0, r_rdata.flags, r_rdata.ag,
                                                  r_rdata.key};
                            3'd1: o_data_word <= {16'd0, r_rdata.pos};
                            3'd2: o_data_word <= {9'd0, r_rdata.motion, r_rdata.alt};
                            3'd3: o_data_word <= r_rdata.call;
                            3'd4: o_data_word <= r_rdata.sqk;
                            3'd5: o_data_word <= r_rdata.times;
                            default: o_data_word <= {32'd0, r_rdata.cnt};
                        endcase
                    end
                end
            endcase
        end
    end
endmodule

// ===== rtl/core/ttt_ctrl.sv =====
// ttt_ctrl: request sequencer of the tracked target table.
// Depends on ttt_pkg; issues commands to ttt_datapath.
`timescale 1ns / 1ps
module ttt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [1:0]     i_op,
    output logic           o_busy,
    output ttt_pkg::t_cmd  o_cmd,
    input  ttt_pkg::t_stat i_stat
);
    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_SCAN    = 9'b000000010,
        S_SCANEND = 9'b000000100,
        S_UPDRD   = 9'b000001000,
        S_UPDWR   = 9'b000010000,
        S_RESP    = 9'b000100000,
        S_RDRD    = 9'b001000000,
        S_WORDS   = 9'b010000000,
        S_DONE    = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic [1:0] r_op;
    logic [2:0] r_word, n_word;

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_word  = r_word;
        o_cmd   = '0;
        o_cmd.word = r_word;
        unique case (r_state)
            S_IDLE: begin
                if (i_start && i_op != ttt_pkg::OP_UNUSED) begin
                    o_cmd.latch = 1'b1;
                    n_word = '0;
                    n_state = (i_op == ttt_pkg::OP_READ) ? S_RDRD : S_SCAN;
                end
            end
            S_SCAN: begin
                // read slot i, evaluate slot i-1 from last cycle's read
                o_cmd.scan_rd  = 1'b1;
                o_cmd.scan_inc = !i_stat.scan_done;
                o_cmd.scan_eval = (r_word != '0);
                n_word = 3'd1;
                if (i_stat.scan_done) n_state = S_SCANEND;
            end
            S_SCANEND: begin
                o_cmd.scan_eval = 1'b1;
                n_state = (r_op == ttt_pkg::OP_UPDATE) ? S_UPDRD : S_RESP;
            end
            S_UPDRD: begin
                if (i_stat.target_ok) begin
                    o_cmd.upd_rd = 1'b1;
                    n_state = S_UPDWR;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_UPDWR: begin
                o_cmd.upd_wr = 1'b1;
                n_state = S_RESP;
            end
            S_RESP: begin
                o_cmd.emit = 1'b1;
                n_state = S_DONE;
            end
            S_RDRD: begin
                o_cmd.rd_rd = 1'b1;
                n_word = '0;
                n_state = S_WORDS;
            end
            S_WORDS: begin
                o_cmd.emit = 1'b1;
                n_word = r_word + 3'd1;
                if (!i_stat.read_ok || r_word == ttt_pkg::LAST_WORD) n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_word  <= '0;
            r_op    <= '0;
        end else begin
            r_state <= n_state;
            r_word  <= n_word;
            if (o_cmd.latch) r_op <= i_op;
        end
    end
endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking testbench of tracked_target_table.
// A scoreboard class predicts each result word; depends on ttt_pkg and the block.
`timescale 1ns / 1ps
module tb_top;
    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 100;

    typedef struct {
        logic [1:0]  op;
        logic [31:0] now;
        logic [24:0] address;
        logic [1:0]  airground;
        logic [6:0]  mask;
        logic [23:0] lat;
        logic [23:0] lon;
        logic [17:0] alt;
        logic [8:0]  track;
        logic [11:0] speed;
        logic [15:0] vrate;
        logic [63:0] ident;
    } t_request;

    typedef struct {
        logic [2:0]  status;
        logic [2:0]  index;
        logic [63:0] data;
        logic        last;
    } t_word;

    class track_scoreboard;
        logic [15:0] expiry;
        logic        used [ttt_pkg::TABLE_ENTRIES];
        logic [24:0] key [ttt_pkg::TABLE_ENTRIES];
        logic [1:0]  ag [ttt_pkg::TABLE_ENTRIES];
        logic [6:0]  flags [ttt_pkg::TABLE_ENTRIES];
        logic [47:0] position [ttt_pkg::TABLE_ENTRIES];
        logic [17:0] altitude [ttt_pkg::TABLE_ENTRIES];
        logic [36:0] motion [ttt_pkg::TABLE_ENTRIES];
        logic [63:0] callsign [ttt_pkg::TABLE_ENTRIES];
        logic [63:0] squawk [ttt_pkg::TABLE_ENTRIES];
        logic [63:0] times [ttt_pkg::TABLE_ENTRIES];
        logic [31:0] msg_count [ttt_pkg::TABLE_ENTRIES];
        logic [31:0] total;
        t_word       expected_words [$];
        int          errors;

        function void clear();
            expiry = ttt_pkg::EXPIRY_RESET;
            total = '0;
            errors = 0;
            for (int i = 0; i < ttt_pkg::TABLE_ENTRIES; i++) used[i] = 1'b0;
        endfunction

        function void push(logic [2:0] st, logic [2:0] idx, logic [63:0] data, logic last);
            t_word w;
            w.status = st; w.index = idx; w.data = data; w.last = last;
            expected_words.push_back(w);
        endfunction

        function void note_request(t_request r);
            int hit;
            int free_slot;
            logic [2:0] st;
            logic [6:0] m;
            logic [31:0] age;
            logic [31:0] freed;
            case (r.op)
                ttt_pkg::OP_UPDATE: begin
                    total++;
                    hit = -1;
                    free_slot = -1;
                    st = ttt_pkg::ST_UPDATED;
                    for (int i = 0; i < ttt_pkg::TABLE_ENTRIES; i++) begin
                        if (used[i]) begin
                            if (hit < 0 && key[i] == r.address) hit = i;
                        end else if (free_slot < 0) begin
                            free_slot = i;
                        end
                    end
                    if (hit < 0 && free_slot < 0) begin
                        push(ttt_pkg::ST_FULL, 3'd0, 64'd0, 1'b1);
                        return;
                    end
                    if (hit < 0) begin
                        hit = free_slot;
                        used[hit] = 1'b1;
                        key[hit] = r.address;
                        ag[hit] = ttt_pkg::AG_NO_UPDATE;
                        flags[hit] = '0;
                        position[hit] = '0;
                        altitude[hit] = '0;
                        motion[hit] = '0;
                        callsign[hit] = '0;
                        squawk[hit] = '0;
                        times[hit] = '0;
                        msg_count[hit] = '0;
                        st = ttt_pkg::ST_CREATED;
                    end
                    msg_count[hit]++;
                    times[hit][63:32] = r.now;
                    if (r.airground != ttt_pkg::AG_NO_UPDATE) ag[hit] = r.airground;
                    m = r.mask;
                    if (m[0]) begin
                        position[hit] = {r.lat, r.lon};
                        times[hit][31:0] = r.now;
                    end
                    if (m[1]) altitude[hit] = r.alt;
                    if (m[2]) motion[hit][36:28] = r.track;
                    if (m[3]) motion[hit][27:16] = r.speed;
                    if (m[4]) motion[hit][15:0] = r.vrate;
                    // callsign wins over squawk
                    if (m[5]) begin
                        callsign[hit] = r.ident;
                        m[6] = 1'b0;
                    end else if (m[6]) begin
                        squawk[hit] = r.ident;
                    end
                    flags[hit] = flags[hit] | m;
                    push(st, 3'd0, 64'd0, 1'b1);
                end
                ttt_pkg::OP_SWEEP: begin
                    freed = '0;
                    for (int i = 0; i < ttt_pkg::TABLE_ENTRIES; i++) begin
                        if (used[i]) begin
                            age = r.now - times[i][63:32];
                            if (!age[31] && age > {16'd0, expiry}) begin
                                used[i] = 1'b0;
                                freed++;
                            end
                        end
                    end
                    push(ttt_pkg::ST_SWEPT, 3'd0, {freed, total}, 1'b1);
                end
                ttt_pkg::OP_READ: begin
                    if (r.address >= ttt_pkg::TABLE_ENTRIES || !used[r.address]) begin
                        push(ttt_pkg::ST_EMPTY, 3'd0, 64'd0, 1'b1);
                    end else begin
                        hit = int'(r.address);
                        push(ttt_pkg::ST_WORD, 3'd0,
                             {30'd0, flags[hit], ag[hit], key[hit]}, 1'b0);
                        push(ttt_pkg::ST_WORD, 3'd1, {16'd0, position[hit]}, 1'b0);
                        push(ttt_pkg::ST_WORD, 3'd2,
                             {9'd0, motion[hit], altitude[hit]}, 1'b0);
                        push(ttt_pkg::ST_WORD, 3'd3, callsign[hit], 1'b0);
                        push(ttt_pkg::ST_WORD, 3'd4, squawk[hit], 1'b0);
                        push(ttt_pkg::ST_WORD, 3'd5, times[hit], 1'b0);
                        push(ttt_pkg::ST_WORD, ttt_pkg::LAST_WORD,
                             {32'd0, msg_count[hit]}, 1'b1);
                    end
                end
                default: ;
            endcase
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_word(t_word got);
            t_word w;
            if (expected_words.size() == 0) begin
                report($sformatf("unexpected word st=%0d idx=%0d data=%h last=%0d",
                                 got.status, got.index, got.data, got.last));
                return;
            end
            w = expected_words.pop_front();
            if (got.status !== w.status || got.index !== w.index || got.data !== w.data ||
                got.last !== w.last)
                report($sformatf("got st=%0d idx=%0d data=%h last=%0d, want %0d %0d %h %0d",
                                 got.status, got.index, got.data, got.last,
                                 w.status, w.index, w.data, w.last));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;
    logic        i_start;
    logic        o_busy;
    logic [1:0]  i_op;
    logic [31:0] i_now_seconds;
    logic [24:0] i_address;
    logic [1:0]  i_airground;
    logic [6:0]  i_present_mask;
    logic signed [23:0] i_latitude;
    logic signed [23:0] i_longitude;
    logic signed [17:0] i_altitude_feet;
    logic [8:0]  i_track_degrees;
    logic [11:0] i_speed_knots;
    logic signed [15:0] i_vertical_rate;
    logic [63:0] i_ident_text;
    logic        o_valid;
    logic [2:0]  o_status;
    logic [2:0]  o_word_index;
    logic [63:0] o_data_word;
    logic        o_last;

    tracked_target_table u_dut (.*);

    track_scoreboard sb = new();
    int idle_cycles;
    int burst_left;
    logic [31:0] clock_now;
    logic [24:0] key_pool [16];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check_word('{o_status, o_word_index, o_data_word, o_last});
    end

    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Hold the word until accepted; pause between bursts.
    task send_request(t_request r);
        i_op <= r.op;
        i_now_seconds <= r.now;
        i_address <= r.address;
        i_airground <= r.airground;
        i_present_mask <= r.mask;
        i_latitude <= r.lat;
        i_longitude <= r.lon;
        i_altitude_feet <= r.alt;
        i_track_degrees <= r.track;
        i_speed_knots <= r.speed;
        i_vertical_rate <= r.vrate;
        i_ident_text <= r.ident;
        i_start <= 1'b1;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        sb.note_request(r);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 9);
            i_start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    function t_request random_fields(logic [1:0] op, logic [24:0] addr);
        t_request r;
        r.op = op;
        r.now = clock_now;
        r.address = addr;
        r.airground = 2'($urandom_range(0, 3));
        r.mask = 7'($urandom);
        r.lat = 24'($urandom);
        r.lon = 24'($urandom);
        r.alt = 18'($urandom);
        r.track = 9'($urandom);
        r.speed = 12'($urandom);
        r.vrate = 16'($urandom);
        r.ident = {$urandom, $urandom};
        return r;
    endfunction

    // Stop sending, drain, let the block settle, then write the expiry register.
    task write_expiry(logic [15:0] value);
        i_start <= 1'b0;
        while (sb.expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.expiry = value;
    endtask

    task random_phase(int count);
        t_request r;
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            // mostly small steps, sometimes a big jump or a step back
            case ($urandom_range(0, 19))
                0: clock_now = $urandom;
                1: clock_now = clock_now - $urandom_range(1, 100);
                2: clock_now = clock_now + $urandom_range(200, 70000);
                default: clock_now = clock_now + $urandom_range(0, 60);
            endcase
            if (pick < 60) begin
                r = random_fields(ttt_pkg::OP_UPDATE, key_pool[$urandom_range(0, 15)]);
            end else if (pick < 65) begin
                r = random_fields(ttt_pkg::OP_UPDATE, 25'($urandom));
            end else if (pick < 78) begin
                r = random_fields(ttt_pkg::OP_READ, (pick < 76) ?
                                  25'($urandom_range(0, 20)) : 25'($urandom));
            end else if (pick < 95) begin
                r = random_fields(ttt_pkg::OP_SWEEP, 25'($urandom));
            end else begin
                r = random_fields(ttt_pkg::OP_UNUSED, 25'($urandom));
            end
            send_request(r);
        end
    endtask

    initial begin
        t_request r;
        sb.clear();
        idle_cycles = 0;
        burst_left = 0;
        clock_now = 32'd1000;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        i_start = 1'b0;
        i_op = '0;
        i_now_seconds = '0;
        i_address = '0;
        i_airground = '0;
        i_present_mask = '0;
        i_latitude = '0;
        i_longitude = '0;
        i_altitude_feet = '0;
        i_track_degrees = '0;
        i_speed_knots = '0;
        i_vertical_rate = '0;
        i_ident_text = '0;
        // odd pool entries carry the non-ICAO bit
        for (int i = 0; i < 16; i++) key_pool[i] = {i[0], 24'($urandom)};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, every op, text priority, reserved airground
        r = random_fields(ttt_pkg::OP_UPDATE, 25'd0);
        r.mask = 7'h7F; r.airground = 2'd1; r.lat = 24'sd4194304; r.lon = 24'sh7FFFFF;
        r.alt = 18'sd101350; r.track = 9'd359; r.speed = 12'hFFF; r.vrate = 16'sh7FFF;
        r.ident = '1;
        send_request(r);
        r = random_fields(ttt_pkg::OP_UPDATE, 25'd0);
        r.mask = 7'h00; r.airground = ttt_pkg::AG_NO_UPDATE;
        send_request(r);
        r = random_fields(ttt_pkg::OP_UPDATE, 25'h1FFFFFF);
        r.mask = 7'h40; r.airground = 2'd2; r.lat = -24'sd4194304; r.lon = 24'sh800000;
        r.alt = -18'sd1000; r.track = '0; r.speed = '0; r.vrate = 16'sh8000; r.ident = '0;
        send_request(r);
        r = random_fields(ttt_pkg::OP_UPDATE, 25'h1FFFFFF);
        r.mask = 7'h60; r.airground = ttt_pkg::AG_NO_UPDATE;
        send_request(r);
        r = random_fields(ttt_pkg::OP_UPDATE, 25'h1000000);
        r.mask = 7'h1F;
        send_request(r);
        for (int s = 0; s < 4; s++) send_request(random_fields(ttt_pkg::OP_READ, 25'(s)));
        send_request(random_fields(ttt_pkg::OP_READ, 25'd63));
        send_request(random_fields(ttt_pkg::OP_READ, 25'd64));
        send_request(random_fields(ttt_pkg::OP_READ, 25'h1FFFFFF));
        send_request(random_fields(ttt_pkg::OP_UNUSED, 25'd0));
        r = random_fields(ttt_pkg::OP_SWEEP, 25'd0);
        r.now = clock_now + 32'd300;
        send_request(r);
        r.now = clock_now + 32'd301;
        send_request(r);
        r.now = clock_now - 32'd5;
        send_request(r);
        send_request(random_fields(ttt_pkg::OP_READ, 25'd0));

        write_expiry(16'd0);
        random_phase(10);
        write_expiry(16'hFFFF);
        random_phase(10);
        write_expiry(16'($urandom_range(1, 200)));
        random_phase(10);

        // fill the table past capacity, then read and empty it
        write_expiry(ttt_pkg::EXPIRY_RESET);
        for (int i = 0; i < ttt_pkg::TABLE_ENTRIES + 3; i++)
            send_request(random_fields(ttt_pkg::OP_UPDATE, 25'(25'h0AB000 + i)));
        send_request(random_fields(ttt_pkg::OP_READ, 25'd63));
        clock_now = clock_now + 32'd100000;
        send_request(random_fields(ttt_pkg::OP_SWEEP, 25'd0));
        random_phase(4);

        i_start <= 1'b0;
        while (sb.expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/core/ttt_pkg.sv
rtl/core/ttt_datapath.sv
rtl/core/ttt_ctrl.sv
rtl/core/tracked_target_table.sv
tb/tb_top.sv
